FILE: rtl/core/aarm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aarm_pkg;

    localparam int SqrtSteps   = 32;
    localparam int DivSteps    = 31;
    localparam int CordicSteps = 16;
    localparam int NumLanes    = 3;
    localparam int NumEntries  = 9;

    // Q.30 working values, with headroom for sums a little beyond two.
    typedef logic signed [33:0] q30_t;
    // Angle in Q.16.
    typedef logic signed [19:0] zang_t;
    typedef logic signed [15:0] q14_t;
    typedef logic signed [34:0] sum_t;

    localparam q30_t  OneQ30    = 34'sd1073741824;
    localparam q30_t  CordicK   = 34'sd652032874;
    localparam zang_t PiQ16     = 20'sd205887;
    localparam zang_t HalfPiQ16 = 20'sd102944;
    localparam q14_t  OneQ14    = 16'sd16384;

    // Data that rides along the square root stages.
    typedef struct packed {
        logic                      zero;
        logic [NumLanes-1:0]       sgn;
        logic [NumLanes-1:0][15:0] mag;
        zang_t                     z;
        logic                      neg;
    } side_t;

    function automatic zang_t atan_q16(input int unsigned i);
        zang_t a;
        begin
            case (i)
                0:       a = 20'sd51472;
                1:       a = 20'sd30386;
                2:       a = 20'sd16055;
                3:       a = 20'sd8150;
                4:       a = 20'sd4091;
                5:       a = 20'sd2047;
                6:       a = 20'sd1024;
                7:       a = 20'sd512;
                8:       a = 20'sd256;
                9:       a = 20'sd128;
                10:      a = 20'sd64;
                11:      a = 20'sd32;
                12:      a = 20'sd16;
                13:      a = 20'sd8;
                14:      a = 20'sd4;
                15:      a = 20'sd2;
                default: a = 20'sd0;
            endcase
            return a;
        end
    endfunction

    // Q.30 product, floored.
    function automatic q30_t mulq(input q30_t a, input q30_t b);
        logic signed [67:0] p;
        begin
            p = a * b;
            return p[63:30];
        end
    endfunction

    // Round to Q1.14 and saturate to plus or minus one.
    function automatic q14_t to_q14(input sum_t v);
        sum_t t;
        begin
            t = (v + 35'sd32768) >>> 16;
            if (t > 35'sd16384)
                return OneQ14;
            else if (t < -35'sd16384)
                return -OneQ14;
            return t[15:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/axis_angle_rotation_matrix.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Signals                                   | Transfer
// ---------+-------------------------------------------+-------------------------------
// command  | start, busy, angle, axis_x/y/z            | clock edge with start && !busy
// result   | done, r00..r22, axis_was_zero             | clock edge ending the done cycle
//
// One transfer can be taken every cycle; busy is always low.
// Pipeline stages in order: input, norm, 32 square root stages, 31 divider stages
// (the CORDIC runs beside the first 16 of them), unit, three multiply/sum stages and output.
// Reset clears the valid bits only; data registers are not reset.
// The result side cannot stall, so the pipeline never holds.

module axis_angle_rotation_matrix (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire aarm_pkg::q14_t       angle,
    input  wire aarm_pkg::q14_t       axis_x,
    input  wire aarm_pkg::q14_t       axis_y,
    input  wire aarm_pkg::q14_t       axis_z,
    output logic                      done,
    output aarm_pkg::q14_t            r00,
    output aarm_pkg::q14_t            r01,
    output aarm_pkg::q14_t            r02,
    output aarm_pkg::q14_t            r10,
    output aarm_pkg::q14_t            r11,
    output aarm_pkg::q14_t            r12,
    output aarm_pkg::q14_t            r20,
    output aarm_pkg::q14_t            r21,
    output aarm_pkg::q14_t            r22,
    output logic                      axis_was_zero
);
    import aarm_pkg::*;

    assign busy = 1'b0;

    // ---------------- input stage ----------------
    logic                      in_vld_reg;
    q14_t                      ang0_reg;
    logic [NumLanes-1:0]       sgn0_reg;
    logic [NumLanes-1:0][15:0] mag0_reg;
    logic                      zero0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        ang0_reg    <= angle;
        sgn0_reg    <= {axis_z[15], axis_y[15], axis_x[15]};
        mag0_reg[0] <= axis_x[15] ? 16'(-axis_x) : axis_x;
        mag0_reg[1] <= axis_y[15] ? 16'(-axis_y) : axis_y;
        mag0_reg[2] <= axis_z[15] ? 16'(-axis_z) : axis_z;
        zero0_reg   <= (axis_x == 16'sd0) && (axis_y == 16'sd0) && (axis_z == 16'sd0);
    end

    // ---------------- squared norm and angle reduction ----------------
    logic        n_vld_reg;
    logic [31:0] n2_reg;
    side_t       n_side_reg;
    logic [31:0] n2_next;
    side_t       n_side_next;
    zang_t       z_raw;

    always_comb
    begin
        z_raw   = {ang0_reg[15], ang0_reg, 3'b000};
        n2_next = 32'(mag0_reg[0]) * 32'(mag0_reg[0])
                + 32'(mag0_reg[1]) * 32'(mag0_reg[1])
                + 32'(mag0_reg[2]) * 32'(mag0_reg[2]);
        n_side_next.zero = zero0_reg;
        n_side_next.sgn  = sgn0_reg;
        n_side_next.mag  = mag0_reg;
        if (z_raw > HalfPiQ16)
        begin
            n_side_next.z   = z_raw - PiQ16;
            n_side_next.neg = 1'b1;
        end
        else if (z_raw < -HalfPiQ16)
        begin
            n_side_next.z   = z_raw + PiQ16;
            n_side_next.neg = 1'b1;
        end
        else
        begin
            n_side_next.z   = z_raw;
            n_side_next.neg = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_vld_reg <= 1'b0;
        else
            n_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        n2_reg     <= n2_next;
        n_side_reg <= n_side_next;
    end

    // ---------------- square root, one result bit per stage ----------------
    logic        sq_vld_reg  [SqrtSteps];
    logic [63:0] sq_n_reg    [SqrtSteps];
    logic [63:0] sq_res_reg  [SqrtSteps];
    side_t       sq_side_reg [SqrtSteps];

    for (genvar k = 0; k < SqrtSteps; k++)
    begin : g_sqrt
        localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
        logic        vld_in;
        logic [63:0] n_in;
        logic [63:0] res_in;
        side_t       side_in;
        logic [63:0] trial;
        logic [63:0] n_next;
        logic [63:0] res_next;

        if (k == 0)
        begin : g_first
            assign vld_in  = n_vld_reg;
            assign n_in    = {n2_reg, 32'd0};
            assign res_in  = 64'd0;
            assign side_in = n_side_reg;
        end
        else
        begin : g_rest
            assign vld_in  = sq_vld_reg[k-1];
            assign n_in    = sq_n_reg[k-1];
            assign res_in  = sq_res_reg[k-1];
            assign side_in = sq_side_reg[k-1];
        end

        always_comb
        begin
            trial = res_in + Bit;
            if (n_in >= trial)
            begin
                n_next   = n_in - trial;
                res_next = (res_in >> 1) + Bit;
            end
            else
            begin
                n_next   = n_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[k] <= 1'b0;
            else
                sq_vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            sq_n_reg[k]    <= n_next;
            sq_res_reg[k]  <= res_next;
            sq_side_reg[k] <= side_in;
        end
    end

    // ---------------- restoring divide per lane, CORDIC alongside ----------------
    logic                vd_vld_reg  [DivSteps];
    logic                vd_zero_reg [DivSteps];
    logic [NumLanes-1:0] vd_sgn_reg  [DivSteps];
    logic [31:0]         vd_r_reg    [DivSteps];
    logic [62:0]         vd_rem_reg  [DivSteps][NumLanes];
    logic [30:0]         vd_q_reg    [DivSteps][NumLanes];
    q30_t                cx_reg      [DivSteps];
    q30_t                cy_reg      [DivSteps];
    zang_t               cz_reg      [DivSteps];
    logic                cneg_reg    [DivSteps];

    for (genvar j = 0; j < DivSteps; j++)
    begin : g_div
        localparam int QBit = DivSteps - 1 - j;
        logic                vld_in;
        logic                zero_in;
        logic [NumLanes-1:0] sgn_in;
        logic [31:0]         r_in;
        logic [62:0]         rem_in [NumLanes];
        logic [30:0]         q_in   [NumLanes];
        logic [62:0]         rem_next [NumLanes];
        logic [30:0]         q_next   [NumLanes];
        logic [62:0]         dsh;
        q30_t                x_in;
        q30_t                y_in;
        zang_t               z_in;
        logic                neg_in;
        q30_t                x_next;
        q30_t                y_next;
        zang_t               z_next;

        if (j == 0)
        begin : g_first
            assign vld_in  = sq_vld_reg[SqrtSteps-1];
            assign zero_in = sq_side_reg[SqrtSteps-1].zero;
            assign sgn_in  = sq_side_reg[SqrtSteps-1].sgn;
            assign r_in    = sq_res_reg[SqrtSteps-1][31:0];
            for (genvar l = 0; l < NumLanes; l++)
            begin : g_lane
                assign rem_in[l] = 63'(sq_side_reg[SqrtSteps-1].mag[l]) << 46;
                assign q_in[l]   = 31'd0;
            end
            assign x_in   = CordicK;
            assign y_in   = 34'sd0;
            assign z_in   = sq_side_reg[SqrtSteps-1].z;
            assign neg_in = sq_side_reg[SqrtSteps-1].neg;
        end
        else
        begin : g_rest
            assign vld_in  = vd_vld_reg[j-1];
            assign zero_in = vd_zero_reg[j-1];
            assign sgn_in  = vd_sgn_reg[j-1];
            assign r_in    = vd_r_reg[j-1];
            for (genvar l = 0; l < NumLanes; l++)
            begin : g_lane
                assign rem_in[l] = vd_rem_reg[j-1][l];
                assign q_in[l]   = vd_q_reg[j-1][l];
            end
            assign x_in   = cx_reg[j-1];
            assign y_in   = cy_reg[j-1];
            assign z_in   = cz_reg[j-1];
            assign neg_in = cneg_reg[j-1];
        end

        assign dsh = 63'(r_in) << QBit;

        for (genvar l = 0; l < NumLanes; l++)
        begin : g_step
            always_comb
            begin
                rem_next[l] = rem_in[l];
                q_next[l]   = q_in[l];
                if (rem_in[l] >= dsh)
                begin
                    rem_next[l]     = rem_in[l] - dsh;
                    q_next[l][QBit] = 1'b1;
                end
            end
        end

        if (j < CordicSteps)
        begin : g_cordic
            always_comb
            begin
                if (!z_in[19])
                begin
                    x_next = x_in - (y_in >>> j);
                    y_next = y_in + (x_in >>> j);
                    z_next = z_in - atan_q16(j);
                end
                else
                begin
                    x_next = x_in + (y_in >>> j);
                    y_next = y_in - (x_in >>> j);
                    z_next = z_in + atan_q16(j);
                end
            end
        end
        else
        begin : g_hold
            assign x_next = x_in;
            assign y_next = y_in;
            assign z_next = z_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vd_vld_reg[j] <= 1'b0;
            else
                vd_vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            vd_zero_reg[j] <= zero_in;
            vd_sgn_reg[j]  <= sgn_in;
            vd_r_reg[j]    <= r_in;
            for (int l = 0; l < NumLanes; l++)
            begin
                vd_rem_reg[j][l] <= rem_next[l];
                vd_q_reg[j][l]   <= q_next[l];
            end
            cx_reg[j]   <= x_next;
            cy_reg[j]   <= y_next;
            cz_reg[j]   <= z_next;
            cneg_reg[j] <= neg_in;
        end
    end

    // ---------------- unit vector, sine and cosine ----------------
    logic u_vld_reg;
    logic u_zero_reg;
    q30_t u_reg [NumLanes];
    q30_t c_reg;
    q30_t s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            u_vld_reg <= 1'b0;
        else
            u_vld_reg <= vd_vld_reg[DivSteps-1];
    end

    always_ff @(posedge clk)
    begin
        u_zero_reg <= vd_zero_reg[DivSteps-1];
        for (int l = 0; l < NumLanes; l++)
        begin
            if (vd_sgn_reg[DivSteps-1][l])
                u_reg[l] <= -$signed({3'b000, vd_q_reg[DivSteps-1][l]});
            else
                u_reg[l] <= $signed({3'b000, vd_q_reg[DivSteps-1][l]});
        end
        c_reg <= cneg_reg[DivSteps-1] ? -cx_reg[DivSteps-1] : cx_reg[DivSteps-1];
        s_reg <= cneg_reg[DivSteps-1] ? -cy_reg[DivSteps-1] : cy_reg[DivSteps-1];
    end

    // ---------------- first products ----------------
    logic m1_vld_reg;
    logic m1_zero_reg;
    q30_t sq1_reg  [NumLanes];   // squares of x, y, z
    q30_t pr1_reg  [NumLanes];   // xy, xz, yz
    q30_t us1_reg  [NumLanes];   // x*s, y*s, z*s
    q30_t c1_reg;
    q30_t omc1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_vld_reg <= 1'b0;
        else
            m1_vld_reg <= u_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        m1_zero_reg <= u_zero_reg;
        for (int l = 0; l < NumLanes; l++)
        begin
            sq1_reg[l] <= mulq(u_reg[l], u_reg[l]);
            us1_reg[l] <= mulq(u_reg[l], s_reg);
        end
        pr1_reg[0] <= mulq(u_reg[0], u_reg[1]);
        pr1_reg[1] <= mulq(u_reg[0], u_reg[2]);
        pr1_reg[2] <= mulq(u_reg[1], u_reg[2]);
        c1_reg     <= c_reg;
        omc1_reg   <= OneQ30 - c_reg;
    end

    // ---------------- second products ----------------
    logic m2_vld_reg;
    logic m2_zero_reg;
    q30_t sq2_reg [NumLanes];
    q30_t dg2_reg [NumLanes];
    q30_t pr2_reg [NumLanes];
    q30_t us2_reg [NumLanes];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m2_vld_reg <= 1'b0;
        else
            m2_vld_reg <= m1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        m2_zero_reg <= m1_zero_reg;
        for (int l = 0; l < NumLanes; l++)
        begin
            sq2_reg[l] <= sq1_reg[l];
            dg2_reg[l] <= mulq(OneQ30 - sq1_reg[l], c1_reg);
            pr2_reg[l] <= mulq(pr1_reg[l], omc1_reg);
            us2_reg[l] <= us1_reg[l];
        end
    end

    // ---------------- entry sums ----------------
    logic m3_vld_reg;
    logic m3_zero_reg;
    sum_t m3_reg [NumEntries];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m3_vld_reg <= 1'b0;
        else
            m3_vld_reg <= m2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        m3_zero_reg <= m2_zero_reg;
        m3_reg[0] <= 35'(sq2_reg[0]) + 35'(dg2_reg[0]);
        m3_reg[1] <= 35'(pr2_reg[0]) - 35'(us2_reg[2]);
        m3_reg[2] <= 35'(pr2_reg[1]) + 35'(us2_reg[1]);
        m3_reg[3] <= 35'(pr2_reg[0]) + 35'(us2_reg[2]);
        m3_reg[4] <= 35'(sq2_reg[1]) + 35'(dg2_reg[1]);
        m3_reg[5] <= 35'(pr2_reg[2]) - 35'(us2_reg[0]);
        m3_reg[6] <= 35'(pr2_reg[1]) - 35'(us2_reg[1]);
        m3_reg[7] <= 35'(pr2_reg[2]) + 35'(us2_reg[0]);
        m3_reg[8] <= 35'(sq2_reg[2]) + 35'(dg2_reg[2]);
    end

    // ---------------- output register ----------------
    logic done_reg;
    logic zero_out_reg;
    q14_t ent_reg [NumEntries];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= m3_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        zero_out_reg <= m3_zero_reg;
        for (int e = 0; e < NumEntries; e++)
        begin
            // A zero axis gives the identity, whatever the datapath made of it.
            if (m3_zero_reg)
                ent_reg[e] <= (e % 4 == 0) ? OneQ14 : 16'sd0;
            else
                ent_reg[e] <= to_q14(m3_reg[e]);
        end
    end

    assign done          = done_reg;
    assign axis_was_zero = zero_out_reg;
    assign r00 = ent_reg[0];
    assign r01 = ent_reg[1];
    assign r02 = ent_reg[2];
    assign r10 = ent_reg[3];
    assign r11 = ent_reg[4];
    assign r12 = ent_reg[5];
    assign r20 = ent_reg[6];
    assign r21 = ent_reg[7];
    assign r22 = ent_reg[8];

endmodule

`default_nettype wire
